// ===== hdl/qmn_pkg.sv =====
// qmn_pkg: shared types and widths for the normalized quaternion product.
// No dependencies.
`default_nettype none

package qmn_pkg;

	localparam int CW = 32;   // input/output component width
	localparam int MW = 35;   // product component magnitude width
	localparam int SW = 72;   // sum of squares width
	localparam int RW = 36;   // norm (root) width
	localparam int QW = 31;   // quotient width

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} comp_t;

	typedef comp_t [3:0] quat_t;

endpackage

`default_nettype wire

// ===== hdl/qmn_prod.sv =====
// qmn_prod: exact Hamilton product, floor shift by 30, sign/magnitude split.
// Three register stages. Depends on qmn_pkg.
`default_nettype none

module qmn_prod import qmn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [3:0][CW-1:0]   now_q,
	input  wire logic [3:0][CW-1:0]   old_q,
	output logic                      out_valid,
	output quat_t                     quat
);

	// bit i set: term i of component k is subtracted
	localparam logic [3:0] TERM_SUB [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	logic signed [2*CW-1:0] prod_s1 [4][4];
	logic signed [MW:0]     comp_s2 [4];
	quat_t                  quat_s3;
	logic                   valid_s1, valid_s2, valid_s3;
	logic signed [MW:0]     comp_c [4];

	for (genvar k = 0; k < 4; k++) begin : g_row
		for (genvar i = 0; i < 4; i++) begin : g_term
			localparam int J = i ^ k;
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s1[k][i] <= $signed(now_q[i]) * $signed(old_q[J]);
				end
			end
		end
	end

	always_comb begin
		logic signed [2*CW+1:0] acc;
		for (int k = 0; k < 4; k++) begin
			acc = '0;
			for (int i = 0; i < 4; i++) begin
				if (TERM_SUB[k][i]) begin
					acc = acc - {{2{prod_s1[k][i][2*CW-1]}}, prod_s1[k][i]};
				end else begin
					acc = acc + {{2{prod_s1[k][i][2*CW-1]}}, prod_s1[k][i]};
				end
			end
			comp_c[k] = acc[2*CW+1:30];
		end
	end

	always_ff @(posedge clk) begin
		logic [MW:0] negv;
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				comp_s2[k] <= comp_c[k];
				negv = -comp_s2[k];
				quat_s3[k].neg <= comp_s2[k][MW];
				quat_s3[k].mag <= comp_s2[k][MW] ? negv[MW-1:0] : comp_s2[k][MW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign quat      = quat_s3;

endmodule

`default_nettype wire

// ===== hdl/qmn_norm.sv =====
// qmn_norm: sum of squares and bit-per-stage integer square root.
// 3 + 36 register stages. Depends on qmn_pkg.
`default_nettype none

module qmn_norm import qmn_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_valid,
	input  wire quat_t   in_quat,
	output logic         out_valid,
	output quat_t        out_quat,
	output logic [RW-1:0] root
);

	logic [63:0]   ll_s1 [4];
	logic [MW-1:0] hl_s1 [4];
	logic [5:0]    hh_s1 [4];
	logic [SW-1:0] sqr_s2 [4];
	logic [SW-1:0] sum_s3;
	quat_t         quat_s1, quat_s2, quat_s3;
	logic          valid_s1, valid_s2, valid_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				ll_s1[l]  <= 64'(in_quat[l].mag[31:0]) * 64'(in_quat[l].mag[31:0]);
				hl_s1[l]  <= MW'(in_quat[l].mag[MW-1:32]) * MW'(in_quat[l].mag[31:0]);
				hh_s1[l]  <= 6'(in_quat[l].mag[MW-1:32]) * 6'(in_quat[l].mag[MW-1:32]);
				sqr_s2[l] <= (SW'(hh_s1[l]) << 64) + (SW'(hl_s1[l]) << 33) + SW'(ll_s1[l]);
			end
			sum_s3  <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2] + sqr_s2[3];
			quat_s1 <= in_quat;
			quat_s2 <= quat_s1;
			quat_s3 <= quat_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	logic [SW-1:0] rad_p   [RW+1];
	logic [RW+1:0] rem_p   [RW+1];
	logic [RW-1:0] root_p  [RW+1];
	quat_t         quat_p  [RW+1];
	logic          valid_p [RW+1];

	assign rad_p[0]   = sum_s3;
	assign rem_p[0]   = '0;
	assign root_p[0]  = '0;
	assign quat_p[0]  = quat_s3;
	assign valid_p[0] = valid_s3;

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [SW-1:0] rad_s;
		logic [RW+1:0] rem_s;
		logic [RW-1:0] root_s;
		quat_t         quat_s;
		logic          valid_s;
		logic [RW+3:0] rem2, trial, diff;
		logic          ge;

		always_comb begin
			rem2  = {rem_p[k], rad_p[k][SW-1:SW-2]};
			trial = {2'b00, root_p[k], 2'b01};
			ge    = rem2 >= trial;
			diff  = rem2 - trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s  <= {rad_p[k][SW-3:0], 2'b00};
				rem_s  <= ge ? diff[RW+1:0] : rem2[RW+1:0];
				root_s <= {root_p[k][RW-2:0], ge};
				quat_s <= quat_p[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s <= 1'b0;
			end else if (en) begin
				valid_s <= valid_p[k];
			end
		end

		assign rad_p[k+1]   = rad_s;
		assign rem_p[k+1]   = rem_s;
		assign root_p[k+1]  = root_s;
		assign quat_p[k+1]  = quat_s;
		assign valid_p[k+1] = valid_s;
	end

	assign out_valid = valid_p[RW];
	assign out_quat  = quat_p[RW];
	assign root      = root_p[RW];

endmodule

`default_nettype wire

// ===== hdl/qmn_div.sv =====
// qmn_div: four lanes of restoring division, magnitude * 2^30 / root.
// 31 register stages, one quotient bit each. Depends on qmn_pkg.
`default_nettype none

module qmn_div import qmn_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire quat_t         in_quat,
	input  wire logic [RW-1:0] root,
	output logic               out_valid,
	output logic [3:0]         neg,
	output logic [3:0][QW-1:0] quot,
	output logic               degenerate
);

	logic [RW:0]         rem_p   [QW+1][4];
	logic [QW-1:0]       q_p     [QW+1][4];
	logic [3:0]          neg_p   [QW+1];
	logic [3:0]          lsb_p   [QW+1];
	logic [RW-1:0]       r_p     [QW+1];
	logic                valid_p [QW+1];

	for (genvar l = 0; l < 4; l++) begin : g_init
		assign rem_p[0][l] = (RW+1)'(in_quat[l].mag >> 1);
		assign q_p[0][l]   = '0;
		assign neg_p[0][l] = in_quat[l].neg;
		assign lsb_p[0][l] = in_quat[l].mag[0];
	end
	assign r_p[0]     = root;
	assign valid_p[0] = in_valid;

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [RW:0]   rem_s [4];
		logic [QW-1:0] q_s   [4];
		logic [3:0]    neg_s;
		logic [RW-1:0] r_s;
		logic          valid_s;

		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [RW+1:0] r2, diff;
			logic          ge;

			always_comb begin
				r2   = {rem_p[j][l], (j == 0) ? lsb_p[j][l] : 1'b0};
				ge   = r2 >= {2'b00, r_p[j]};
				diff = r2 - {2'b00, r_p[j]};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l] <= ge ? diff[RW:0] : r2[RW:0];
					q_s[l]   <= {q_p[j][l][QW-2:0], ge};
				end
			end

			assign rem_p[j+1][l] = rem_s[l];
			assign q_p[j+1][l]   = q_s[l];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s <= neg_p[j];
				r_s   <= r_p[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s <= 1'b0;
			end else if (en) begin
				valid_s <= valid_p[j];
			end
		end

		assign neg_p[j+1]   = neg_s;
		assign lsb_p[j+1]   = '0;
		assign r_p[j+1]     = r_s;
		assign valid_p[j+1] = valid_s;
	end

	for (genvar l = 0; l < 4; l++) begin : g_out
		assign quot[l] = q_p[QW][l];
	end

	assign out_valid  = valid_p[QW];
	assign neg        = neg_p[QW];
	assign degenerate = (r_p[QW] == '0);

endmodule

`default_nettype wire

// ===== hdl/quaternion_multiply_normalize.sv =====
// quaternion_multiply_normalize: top level, normalized Hamilton product.
// Depends on qmn_pkg, qmn_prod, qmn_norm, qmn_div.
//
//   channel  dir  tdata                                  tuser
//   s_       in   now_w,now_x,now_y,now_z,old_w..old_z   -
//   m_       out  res_w,res_x,res_y,res_z                degenerate
//
// One word per cycle sustained while the output is not stalled; pipeline stages: 3 product,
// 39 norm with one root bit per stage, 31 divide with one quotient bit per stage, 1 output.
// Reset clears only the valid bits. The whole pipeline holds while the output
// word waits; s_tready = !m_tvalid || m_tready.
`default_nettype none

module quaternion_multiply_normalize import qmn_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [255:0] s_tdata,   // now_w, now_x, now_y, now_z, old_w, old_x, old_y, old_z
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // res_w, res_x, res_y, res_z
	output logic [0:0]        m_tuser    // degenerate
);

	logic               en;
	logic               prod_valid, norm_valid, div_valid;
	quat_t              prod_quat, norm_quat;
	logic [RW-1:0]      root;
	logic [3:0]         neg;
	logic [3:0][QW-1:0] quot;
	logic               degenerate;
	logic [3:0][CW-1:0] now_q, old_q;
	logic [127:0]       res_c;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	for (genvar l = 0; l < 4; l++) begin : g_unpack
		assign now_q[l] = s_tdata[CW*l +: CW];
		assign old_q[l] = s_tdata[CW*(l+4) +: CW];
	end

	qmn_prod u_prod (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid && s_tready),
		.now_q(now_q), .old_q(old_q), .out_valid(prod_valid), .quat(prod_quat)
	);

	qmn_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(prod_valid),
		.in_quat(prod_quat), .out_valid(norm_valid), .out_quat(norm_quat), .root(root)
	);

	qmn_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(norm_valid),
		.in_quat(norm_quat), .root(root), .out_valid(div_valid),
		.neg(neg), .quot(quot), .degenerate(degenerate)
	);

	always_comb begin
		logic [CW-1:0] mag;
		for (int l = 0; l < 4; l++) begin
			mag = CW'(quot[l]);
			if (degenerate) begin
				res_c[CW*l +: CW] = '0;
			end else begin
				res_c[CW*l +: CW] = neg[l] ? -mag : mag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res_c;
			m_tuser <= degenerate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= div_valid;
		end
	end

endmodule

`default_nettype wire

// ===== tb/qmn_checker.sv =====
// qmn_checker: watches both stream channels of the normalized quaternion product,
// predicts each result word from the accepted input word and compares field by field.
// Depends on nothing but the clock, the reset and the channel signals.
`default_nettype none

module qmn_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [255:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [127:0] m_tdata,
	input  wire logic [0:0]   m_tuser,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] comp [4];
		logic        degenerate;
	} norm_quat_t;

	norm_quat_t expected_q [$];

	initial fail_count = 0;
	assign pending = expected_q.size();

	// floor(sqrt(s)), s < 2^72
	function automatic logic [35:0] isqrt72(input logic [71:0] s);
		logic [35:0] r;
		logic [35:0] c;
		r = '0;
		for (int b = 35; b >= 0; b--) begin
			c = r | (36'd1 << b);
			if ({36'd0, c} * {36'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic norm_quat_t hamilton_normalize(input logic [255:0] d);
		logic signed [31:0]  a [4];
		logic signed [31:0]  b [4];
		logic signed [127:0] prod [4];
		logic signed [127:0] comp_sh [4];
		logic [71:0]         sumsq;
		logic [35:0]         root;
		logic [127:0]        mag;
		logic [127:0]        quo;
		norm_quat_t          res;
		for (int i = 0; i < 4; i++) begin
			a[i] = d[32*i +: 32];
			b[i] = d[128 + 32*i +: 32];
		end
		prod[0] = 128'(a[0]) * b[0] - 128'(a[1]) * b[1] - 128'(a[2]) * b[2] - 128'(a[3]) * b[3];
		prod[1] = 128'(a[0]) * b[1] + 128'(a[1]) * b[0] + 128'(a[2]) * b[3] - 128'(a[3]) * b[2];
		prod[2] = 128'(a[0]) * b[2] - 128'(a[1]) * b[3] + 128'(a[2]) * b[0] + 128'(a[3]) * b[1];
		prod[3] = 128'(a[0]) * b[3] + 128'(a[1]) * b[2] - 128'(a[2]) * b[1] + 128'(a[3]) * b[0];
		sumsq = '0;
		for (int k = 0; k < 4; k++) begin
			comp_sh[k] = prod[k] >>> 30;
			sumsq += 72'(comp_sh[k] * comp_sh[k]);
		end
		root = isqrt72(sumsq);
		res.degenerate = (root == 0);
		for (int k = 0; k < 4; k++) begin
			if (root == 0) begin
				res.comp[k] = '0;
			end else begin
				mag = comp_sh[k][127] ? 128'(-comp_sh[k]) : 128'(comp_sh[k]);
				quo = (mag << 30) / {92'd0, root};
				res.comp[k] = comp_sh[k][127] ? 32'(-quo) : quo[31:0];
			end
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		norm_quat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report("unexpected word", m_tdata[31:0], '0);
				end else begin
					want = expected_q.pop_front();
					for (int k = 0; k < 4; k++)
						if (m_tdata[32*k +: 32] !== want.comp[k])
							report($sformatf("res comp %0d", k), m_tdata[32*k +: 32], want.comp[k]);
					if (m_tuser[0] !== want.degenerate)
						report("degenerate", 32'(m_tuser[0]), 32'(want.degenerate));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(hamilton_normalize(s_tdata));
		end
	end

endmodule

`default_nettype wire

// ===== tb/quaternion_multiply_normalize_tb.sv =====
// quaternion_multiply_normalize_tb: drives quaternion pairs into the block with random
// idling on both sides and gives the verdict; checking is done in qmn_checker.
// Depends on quaternion_multiply_normalize and qmn_checker.
`default_nettype none

module quaternion_multiply_normalize_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 74;
	localparam int N_RANDOM  = 1700;
	localparam int TAIL_FREE = 300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;
	logic         quiet;

	quaternion_multiply_normalize u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	qmn_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5ms;
		$display("** quaternion_multiply_normalize: FAILED **");
		$finish;
	end

	// receiver stall bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready <= 1'b1;
			if (!quiet)
				repeat ($urandom_range(0, 20)) @(negedge clk);
		end
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h4000_0000;
			3:       return 32'hc000_0000;
			4:       return 32'(signed'($urandom_range(0, 64)) - 32);
			5:       return 32'(signed'($urandom_range(0, 2**20)) - 2**19);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [255:0] d);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	initial begin
		logic [255:0] d;
		logic [31:0]  one_q;
		quiet    = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		one_q = 32'h4000_0000;
		send_word('0);                                        // zero norm
		send_word({{4{32'h0}}, {4{32'h1234_5678}}});          // zero norm from one side
		send_word({32'h0, 32'h0, 32'h0, one_q, 32'h0, 32'h0, 32'h0, one_q});
		send_word({8{32'h8000_0000}});
		send_word({8{32'h7fff_ffff}});
		send_word({8{32'hffff_ffff}});
		send_word({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
		send_word({8{32'h0000_0001}});                        // tiny, shift floors toward -1
		send_word({32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'hffff_ffff});
		send_word({32'h0000_8000, 96'h0, 32'h0000_8000, 96'h0});
		for (int i = 0; i < 8; i++) begin
			d = '0;
			d[32*i +: 32] = one_q;
			d[32*((i + 4) % 8) +: 32] = 32'hc000_0000;
			send_word(d);
		end
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - TAIL_FREE)
				quiet = 1'b1;
			if (n == N_RANDOM / 2) begin
				s_tvalid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			for (int i = 0; i < 8; i++)
				d[32*i +: 32] = rand_comp();
			if ($urandom_range(0, 15) == 0)
				d[32*$urandom_range(0, 3) +: 128] = '0;
			send_word(d);
			idle_gap();
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** quaternion_multiply_normalize: PASSED **");
		else
			$display("** quaternion_multiply_normalize: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/qmn_pkg.sv
hdl/qmn_prod.sv
hdl/qmn_norm.sv
hdl/qmn_div.sv
hdl/quaternion_multiply_normalize.sv
tb/qmn_checker.sv
tb/quaternion_multiply_normalize_tb.sv
